/* rtl/core/b64c_pkg.sv */
// Shared types, constants and alphabet functions of the base64 stream codec.
package b64c_pkg;

  localparam int MAX_RESULTS = 4;
  localparam int NUM_W       = 3;
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       msg_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } out_item_t;

  // All results caused by one input transaction, slot 0 first.
  typedef struct packed {
    out_item_t [MAX_RESULTS-1:0] res;
    logic [NUM_W-1:0]            num;
  } batch_t;

  function automatic logic [7:0] enc_char(input logic [5:0] idx);
    logic [7:0] w;
    w = {2'b00, idx};
    if (idx < 6'd26)       enc_char = w + 8'd65;
    else if (idx < 6'd52)  enc_char = w + 8'd71;
    else if (idx < 6'd62)  enc_char = w - 8'd4;
    else if (idx == 6'd62) enc_char = 8'h2B;
    else                   enc_char = 8'h2F;
  endfunction

  // Bit 6 set when the character belongs to the alphabet, low bits its value.
  function automatic logic [6:0] dec_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    dec_value = 7'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = c - 8'h41;
      dec_value = {1'b1, v[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = c - 8'h47;
      dec_value = {1'b1, v[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = c + 8'h04;
      dec_value = {1'b1, v[5:0]};
    end else if (c == 8'h2B) begin
      dec_value = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      dec_value = {1'b1, 6'd63};
    end
  endfunction

endpackage

/* rtl/core/b64c_front.sv */
// Front end: accepts transactions, runs the bit buffer and builds result batches.
module b64c_front import b64c_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_valid,
  input  logic     cfg_data,
  input  logic     in_valid,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     push,
  output batch_t   push_batch
);

  logic        mode_r, mode_nxt;
  logic [11:0] buf_r, buf_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [1:0]  mod4_r, mod4_nxt;
  logic        stop_r, stop_nxt;

  logic        accept;
  logic [11:0] buf8, buf6;
  logic [5:0]  ch0, ch1, flush_ch;
  logic [3:0]  enc_rem, dec_rem;
  logic        two_ch;
  logic [1:0]  nch, mod_after, pads;
  logic [2:0]  total;
  logic [6:0]  dv;
  logic        dec_has_byte;
  logic [7:0]  dec_byte;
  batch_t      batch;

  assign accept = in_valid && !q_full;
  assign buf8   = {buf_r[3:0], in_data.data_byte};
  assign dv     = dec_value(in_data.data_byte);
  assign buf6   = {buf_r[5:0], dv[5:0]};

  always_comb begin
    ch0      = buf8[11:6];
    ch1      = buf8[5:0];
    two_ch   = 1'b1;
    enc_rem  = 4'd0;
    flush_ch = 6'd0;
    case (cnt_r)
      4'd2: begin
        ch0      = buf8[9:4];
        two_ch   = 1'b0;
        enc_rem  = 4'd4;
        flush_ch = {buf8[3:0], 2'b00};
      end
      4'd4: begin
        ch0     = buf8[11:6];
        ch1     = buf8[5:0];
        two_ch  = 1'b1;
        enc_rem = 4'd0;
      end
      default: begin
        ch0      = buf8[7:2];
        two_ch   = 1'b0;
        enc_rem  = 4'd2;
        flush_ch = {buf8[1:0], 4'b0000};
      end
    endcase
    if (!two_ch) ch1 = flush_ch;
  end

  always_comb begin
    dec_has_byte = 1'b0;
    dec_byte     = buf6[7:0];
    dec_rem      = 4'd6;
    case (cnt_r)
      4'd2: begin
        dec_has_byte = 1'b1;
        dec_byte     = buf6[7:0];
        dec_rem      = 4'd0;
      end
      4'd4: begin
        dec_has_byte = 1'b1;
        dec_byte     = buf6[9:2];
        dec_rem      = 4'd2;
      end
      4'd6: begin
        dec_has_byte = 1'b1;
        dec_byte     = buf6[11:4];
        dec_rem      = 4'd4;
      end
      default: begin
        dec_has_byte = 1'b0;
        dec_rem      = 4'd6;
      end
    endcase
    if (stop_r || !dv[6]) dec_has_byte = 1'b0;
  end

  assign nch       = (two_ch || in_data.msg_end) ? 2'd2 : 2'd1;
  assign mod_after = mod4_r + nch;
  assign pads      = in_data.msg_end ? (2'd0 - mod_after) : 2'd0;

  always_comb begin
    logic [2:0] sum;
    sum   = {1'b0, nch} + {1'b0, pads};
    total = (sum > 3'(MAX_RESULTS)) ? 3'(MAX_RESULTS) : sum;
  end

  always_comb begin
    batch = '0;
    if (!mode_r) begin
      batch.num = total;
      for (int i = 0; i < MAX_RESULTS; i++) begin
        if (i == 0)                 batch.res[i].out_byte = enc_char(ch0);
        else if (i == 1 && nch == 2'd2) batch.res[i].out_byte = enc_char(ch1);
        else                        batch.res[i].out_byte = PAD_CHAR;
        batch.res[i].out_valid = 1'b1;
        batch.res[i].out_last  = in_data.msg_end && (3'(i) + 3'd1 == total);
      end
    end else begin
      batch.num = (dec_has_byte || in_data.msg_end) ? 3'd1 : 3'd0;
      batch.res[0].out_byte  = dec_has_byte ? dec_byte : 8'd0;
      batch.res[0].out_valid = dec_has_byte;
      batch.res[0].out_last  = in_data.msg_end;
    end
  end

  // Drop batches that carry no result.
  assign push       = accept && (batch.num != 3'd0);
  assign push_batch = batch;

  always_comb begin
    mode_nxt = mode_r;
    buf_nxt  = buf_r;
    cnt_nxt  = cnt_r;
    mod4_nxt = mod4_r;
    stop_nxt = stop_r;
    if (cfg_valid) begin
      mode_nxt = cfg_data;
      buf_nxt  = 12'd0;
      cnt_nxt  = 4'd0;
      mod4_nxt = 2'd0;
      stop_nxt = 1'b0;
    end else if (accept) begin
      if (in_data.msg_end) begin
        buf_nxt  = 12'd0;
        cnt_nxt  = 4'd0;
        mod4_nxt = 2'd0;
        stop_nxt = 1'b0;
      end else if (!mode_r) begin
        buf_nxt  = buf8;
        cnt_nxt  = enc_rem;
        mod4_nxt = mod_after;
      end else if (!stop_r) begin
        if (!dv[6]) begin
          stop_nxt = 1'b1;
        end else begin
          buf_nxt = buf6;
          cnt_nxt = dec_rem;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      buf_r  <= 12'd0;
      cnt_r  <= 4'd0;
      mod4_r <= 2'd0;
      stop_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      buf_r  <= buf_nxt;
      cnt_r  <= cnt_nxt;
      mod4_r <= mod4_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule

/* rtl/core/b64c_queue.sv */
// Short batch queue between the front end and the result serialiser.
module b64c_queue import b64c_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  batch_t push_batch,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output batch_t pop_batch
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  batch_t        mem [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_batch = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    if (do_pop)  rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    if (do_push && !do_pop)      cnt_nxt = cnt_r + CW'(1);
    else if (!do_push && do_pop) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp_r] <= push_batch;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/b64c_back.sv */
// Back end: takes queued batches, sends results one per cycle while not stalled.
module b64c_back import b64c_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_not_empty,
  input  batch_t    q_batch,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  batch_t     ent_r, ent_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       busy_r, busy_nxt;
  logic       ov_r, ov_nxt;
  out_item_t  od_r, od_nxt;
  logic       can_load, emit, emit_last;

  assign can_load  = !ov_r || !out_stall;
  assign emit      = busy_r && can_load;
  assign emit_last = emit && ({1'b0, idx_r} + 3'd1 == ent_r.num);
  assign q_pop     = q_not_empty && (!busy_r || emit_last);

  always_comb begin
    ent_nxt  = ent_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    ov_nxt   = ov_r;
    od_nxt   = od_r;
    if (can_load) ov_nxt = 1'b0;
    if (emit) begin
      od_nxt  = ent_r.res[idx_r];
      ov_nxt  = 1'b1;
      idx_nxt = idx_r + 2'd1;
    end
    if (emit_last) busy_nxt = 1'b0;
    // Take the next batch as the current one drains.
    if (q_pop) begin
      ent_nxt  = q_batch;
      idx_nxt  = 2'd0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    idx_r <= idx_nxt;
    od_r  <= od_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

/* rtl/core/base64_stream_codec.sv */
// Base64 stream codec: one input transaction a cycle while the queue has room.
// The first result of a transaction passes the queue, the serialiser's batch register
// and its output register. Results leave one per cycle while not stalled; an encoded
// byte makes one or two, up to four at message end; a decoded character at most one.
// Reset (synchronous, rst_n low) clears mode to encode, message state and queue.
module base64_stream_codec import b64c_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic   q_full, push, q_pop, q_not_empty;
  batch_t push_batch, q_batch;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  b64c_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_batch(push_batch)
  );

  b64c_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_batch(push_batch),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_batch (q_batch)
  );

  b64c_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_not_empty(q_not_empty),
    .q_batch    (q_batch),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
